@@ hdl/irc_pkg.sv @@
// ----------------------------------------------------------------------------
// irc_pkg
// shared types and constants for the raw ir pulse capture block
// ----------------------------------------------------------------------------
package irc_pkg;

  localparam int STORE_DEPTH   = 1024;
  localparam int INTERVAL_BITS = 16;
  localparam int IDX_W         = $clog2(STORE_DEPTH);
  localparam int CNT_W         = IDX_W + 1;
  localparam int TIME_W        = 32;
  localparam int KIND_W        = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = QPTR_W + 1;

  localparam logic [TIME_W-1:0] RAW_GAP_RESET   = TIME_W'(50000);
  localparam logic [TIME_W-1:0] BLANK_RESET     = TIME_W'(100000);
  localparam logic [CNT_W-1:0]  MIN_ENTRY_RESET = CNT_W'(8);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_RECV  = 3'd1,
    PH_BLANK = 3'd2,
    PH_FINAL = 3'd3,
    PH_AVAIL = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    K_EDGE  = 2'd0,
    K_POLL  = 2'd1,
    K_CLEAR = 2'd2,
    K_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    VD_NONE     = 2'd0,
    VD_SHORT    = 2'd1,
    VD_OVERFLOW = 2'd2
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_GAP     = 2'd0,
    CFG_BLANK       = 2'd1,
    CFG_MIN_ENTRIES = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                     frame_ready;
    phase_t                   phase;
    logic [CNT_W-1:0]         entry_count;
    verdict_t                 verdict;
    logic [INTERVAL_BITS-1:0] read_data;
  } result_t;

endpackage

@@ hdl/irc_front.sv @@
// ----------------------------------------------------------------------------
// irc_front
// accepts requests, runs the capture state machine and the interval store
// ----------------------------------------------------------------------------
module irc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [irc_pkg::KIND_W-1:0]           in_kind,
  input  logic [irc_pkg::TIME_W-1:0]           in_now_us,
  input  logic [irc_pkg::IDX_W-1:0]            in_read_index,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [irc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [irc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 q_full,
  output logic                                 push_valid,
  output irc_pkg::result_t                     push_data
);

  logic [irc_pkg::TIME_W-1:0]        raw_gap_r;
  logic [irc_pkg::TIME_W-1:0]        blank_r;
  logic [irc_pkg::CNT_W-1:0]         min_entries_r;

  irc_pkg::phase_t                   phase_r, phase_nxt;
  logic [irc_pkg::TIME_W-1:0]        last_edge_r, last_edge_nxt;
  logic [irc_pkg::CNT_W-1:0]         count_r, count_nxt;

  logic [irc_pkg::INTERVAL_BITS-1:0] store [irc_pkg::STORE_DEPTH];
  logic [irc_pkg::INTERVAL_BITS-1:0] mem_q_r;

  logic                              s1_valid_r, s1_valid_nxt;
  irc_pkg::phase_t                   s1_phase_r;
  logic [irc_pkg::CNT_W-1:0]         s1_count_r;
  irc_pkg::verdict_t                 s1_verdict_r;
  logic                              s1_rd_ok_r;

  irc_pkg::kind_t                    kind;
  logic                              accept;
  logic [irc_pkg::TIME_W-1:0]        gap;
  logic                              raw_over;
  logic                              blank_over;
  logic                              store_full;
  logic                              too_short;
  logic                              wr_en;
  logic                              cnt_clr;
  logic                              rd_ok;
  irc_pkg::verdict_t                 verdict_nxt;

  assign kind       = irc_pkg::kind_t'(in_kind);
  assign in_stall   = s1_valid_r && q_full;
  assign accept     = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign gap        = in_now_us - last_edge_r;
  assign raw_over   = gap > raw_gap_r;
  assign blank_over = gap > blank_r;
  assign store_full = count_r == irc_pkg::CNT_W'(irc_pkg::STORE_DEPTH);
  assign too_short  = count_r < min_entries_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_gap_r     <= irc_pkg::RAW_GAP_RESET;
      blank_r       <= irc_pkg::BLANK_RESET;
      min_entries_r <= irc_pkg::MIN_ENTRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (irc_pkg::cfg_idx_t'(cfg_index))
        irc_pkg::CFG_RAW_GAP:     raw_gap_r     <= cfg_data;
        irc_pkg::CFG_BLANK:       blank_r       <= cfg_data;
        irc_pkg::CFG_MIN_ENTRIES: min_entries_r <= cfg_data[irc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      case (kind)
        irc_pkg::K_EDGE: begin
          case (phase_r)
            irc_pkg::PH_START: phase_nxt = irc_pkg::PH_RECV;
            irc_pkg::PH_RECV:  if (raw_over) phase_nxt = irc_pkg::PH_BLANK;
            irc_pkg::PH_BLANK: if (blank_over) phase_nxt = irc_pkg::PH_FINAL;
            default: ;
          endcase
        end
        irc_pkg::K_POLL: begin
          case (phase_r)
            irc_pkg::PH_RECV:  if (raw_over) phase_nxt = irc_pkg::PH_BLANK;
            irc_pkg::PH_BLANK: if (blank_over) phase_nxt = irc_pkg::PH_FINAL;
            irc_pkg::PH_FINAL: begin
              if (too_short || store_full) phase_nxt = irc_pkg::PH_START;
              else                         phase_nxt = irc_pkg::PH_AVAIL;
            end
            default: ;
          endcase
        end
        irc_pkg::K_CLEAR: phase_nxt = irc_pkg::PH_START;
        default: ;
      endcase
    end
  end

  // state machine outputs
  always_comb begin
    wr_en       = 1'b0;
    cnt_clr     = 1'b0;
    verdict_nxt = irc_pkg::VD_NONE;
    rd_ok       = 1'b0;
    if (accept) begin
      case (kind)
        irc_pkg::K_EDGE: begin
          cnt_clr = phase_r == irc_pkg::PH_START;
          wr_en   = (phase_r == irc_pkg::PH_RECV) && !raw_over && !store_full;
        end
        irc_pkg::K_POLL: begin
          if (phase_r == irc_pkg::PH_FINAL) begin
            if (too_short)       verdict_nxt = irc_pkg::VD_SHORT;
            else if (store_full) verdict_nxt = irc_pkg::VD_OVERFLOW;
          end
        end
        irc_pkg::K_READ: rd_ok = {1'b0, in_read_index} < count_r;
        default: ;
      endcase
    end
  end

  always_comb begin
    last_edge_nxt = last_edge_r;
    if (accept && kind == irc_pkg::K_EDGE) last_edge_nxt = in_now_us;
    count_nxt = count_r;
    if (cnt_clr)    count_nxt = '0;
    else if (wr_en) count_nxt = count_r + irc_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= irc_pkg::PH_START;
      last_edge_r <= '0;
      count_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      last_edge_r <= last_edge_nxt;
      count_r     <= count_nxt;
    end
  end

  // interval store
  always_ff @(posedge clk) begin
    if (wr_en) store[count_r[irc_pkg::IDX_W-1:0]] <= gap[irc_pkg::INTERVAL_BITS-1:0];
    if (accept) mem_q_r <= store[in_read_index];
  end

  // result stage
  assign s1_valid_nxt = accept || (s1_valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_phase_r   <= phase_nxt;
      s1_count_r   <= count_nxt;
      s1_verdict_r <= verdict_nxt;
      s1_rd_ok_r   <= rd_ok;
    end
  end

  assign push_valid             = s1_valid_r;
  assign push_data.frame_ready  = s1_phase_r == irc_pkg::PH_AVAIL;
  assign push_data.phase        = s1_phase_r;
  assign push_data.entry_count  = s1_count_r;
  assign push_data.verdict      = s1_verdict_r;
  assign push_data.read_data    = s1_rd_ok_r ? mem_q_r : '0;

endmodule

@@ hdl/irc_queue.sv @@
// ----------------------------------------------------------------------------
// irc_queue
// short result queue between the front and back parts
// ----------------------------------------------------------------------------
module irc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  irc_pkg::result_t push_data,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop,
  output irc_pkg::result_t pop_data
);

  irc_pkg::result_t            slots [irc_pkg::QUEUE_DEPTH];
  logic [irc_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [irc_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [irc_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full      = cnt_r == irc_pkg::QCNT_W'(irc_pkg::QUEUE_DEPTH);
  assign pop_valid = cnt_r != '0;
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_data  = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = wr_ptr_r + irc_pkg::QPTR_W'(1);
    if (do_pop)  rd_ptr_nxt = rd_ptr_r + irc_pkg::QPTR_W'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + irc_pkg::QCNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - irc_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr_r] <= push_data;
  end

endmodule

@@ hdl/irc_back.sv @@
// ----------------------------------------------------------------------------
// irc_back
// output register driving the result channel
// ----------------------------------------------------------------------------
module irc_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  irc_pkg::result_t                      q_data,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_frame_ready,
  output logic [2:0]                            out_phase,
  output logic [irc_pkg::CNT_W-1:0]             out_entry_count,
  output logic [1:0]                            out_verdict,
  output logic [irc_pkg::INTERVAL_BITS-1:0]     out_read_data
);

  logic             out_valid_r, out_valid_nxt;
  irc_pkg::result_t out_data_r;

  assign q_pop         = q_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = q_pop || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_data_r <= q_data;
  end

  assign out_valid       = out_valid_r;
  assign out_frame_ready = out_data_r.frame_ready;
  assign out_phase       = out_data_r.phase;
  assign out_entry_count = out_data_r.entry_count;
  assign out_verdict     = out_data_r.verdict;
  assign out_read_data   = out_data_r.read_data;

endmodule

@@ hdl/ir_raw_pulse_capture.sv @@
// ----------------------------------------------------------------------------
// ir_raw_pulse_capture
// captures an ir remote frame as raw edge-to-edge intervals
// path: a result passes through the front result stage, the result queue and the output register
// throughput: one request per cycle while in_stall is low, limited by the single store write port
// reset: synchronous active-low; phase, count and last edge time clear,
// configuration returns to defaults, the interval store is not cleared
// ----------------------------------------------------------------------------
module ir_raw_pulse_capture (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [irc_pkg::KIND_W-1:0]            in_kind,
  input  logic [irc_pkg::TIME_W-1:0]            in_now_us,
  input  logic [irc_pkg::IDX_W-1:0]             in_read_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_frame_ready,
  output logic [2:0]                            out_phase,
  output logic [irc_pkg::CNT_W-1:0]             out_entry_count,
  output logic [1:0]                            out_verdict,
  output logic [irc_pkg::INTERVAL_BITS-1:0]     out_read_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [irc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [irc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic             q_full;
  logic             push_valid;
  irc_pkg::result_t push_data;
  logic             q_valid;
  logic             q_pop;
  irc_pkg::result_t q_data;

  irc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_now_us     (in_now_us),
    .in_read_index (in_read_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .push_valid    (push_valid),
    .push_data     (push_data)
  );

  irc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  irc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_ready (out_frame_ready),
    .out_phase       (out_phase),
    .out_entry_count (out_entry_count),
    .out_verdict     (out_verdict),
    .out_read_data   (out_read_data)
  );

endmodule
